// File: rtl/blfcd_pkg.sv
package blfcd_pkg;

  localparam int FLASH_BYTES    = 524288;
  localparam int SECTOR_BYTES   = 4096;
  localparam int SEQUENCE_LIMIT = 10;

  localparam int SEQ_DEPTH   = 6;
  localparam int SEQ_IDX_W   = $clog2(SEQ_DEPTH);
  localparam int UNLOCK_LEN  = 3;
  localparam int PROGRAM_LEN = 4;
  localparam int ERASE_LEN   = 6;

  localparam int CFG_ADDR_W = 3;
  localparam logic REG_FLASH_ENABLE = 1'b0;

  localparam logic [14:0] CMD_ADDR_A = 15'h5555;
  localparam logic [14:0] CMD_ADDR_B = 15'h2AAA;
  localparam logic [11:0] PAT_ADDR_A = 12'hAAA;
  localparam logic [11:0] PAT_ADDR_B = 12'h555;

  localparam logic [7:0] CMD_UNLOCK_1 = 8'hAA;
  localparam logic [7:0] CMD_UNLOCK_2 = 8'h55;
  localparam logic [7:0] CMD_ID_ENTRY = 8'h90;
  localparam logic [7:0] CMD_ERASE    = 8'h80;
  localparam logic [7:0] CMD_PROGRAM  = 8'hA0;
  localparam logic [7:0] CMD_SECTOR   = 8'h30;
  localparam logic [7:0] CMD_CHIP     = 8'h10;
  localparam logic [7:0] CMD_RESET    = 8'hF0;
  localparam logic [7:0] ERASED_BYTE  = 8'hFF;

  typedef enum logic [2:0] {
    OP_NONE         = 3'd0,
    OP_PROGRAM      = 3'd1,
    OP_REFUSED      = 3'd2,
    OP_SECTOR_ERASE = 3'd3,
    OP_CHIP_ERASE   = 3'd4
  } flash_op_e;

  typedef enum logic [1:0] {
    SRC_ROM   = 2'd0,
    SRC_FLASH = 2'd1,
    SRC_ID    = 2'd2
  } prg_source_e;

  typedef struct packed {
    logic [15:0] cpu_addr;
    logic [7:0]  write_data;
    logic [7:0]  current_byte;
  } blfcd_in_t;

  typedef struct packed {
    logic [4:0]  prg_bank;
    logic [1:0]  chr_bank;
    logic        nametable_select;
    prg_source_e prg_source;
    flash_op_e   flash_op;
    logic [18:0] flash_offset;
    logic [7:0]  flash_byte;
  } blfcd_out_t;

endpackage

// File: rtl/blfcd_stream_if.sv
interface blfcd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/bank_latch_with_flash_command_decoder_core.sv
// An accepted item enters the input register, and its result then enters the output register.
// Throughput: one item per cycle while the output side takes results.
// An input register and a result register bracket a single pass of decode logic.
// Reset clears the bank latch, the command sequence count, ID mode and flash enable.
// The recorded command entries are not reset; each is written before it is compared.
module bank_latch_with_flash_command_decoder_core
  import blfcd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  blfcd_stream_if.sink          in_i,
  blfcd_stream_if.source        out_o
);

  logic       flash_enable_q, flash_enable_d;
  logic       stg_valid_q, stg_valid_d;
  blfcd_in_t  stg_q;
  logic       res_valid_q, res_valid_d;
  blfcd_out_t res_q, res_d;
  logic [7:0] bank_latch_q, bank_latch_d;
  logic [3:0] seq_count_q, seq_count_d;
  logic       id_mode_q, id_mode_d;
  logic [14:0] seq_addr_q [SEQ_DEPTH];
  logic [7:0]  seq_val_q [SEQ_DEPTH];

  logic        in_fire, advance, cfg_we;
  logic        upper_half, rec_en;
  logic [3:0]  seq_count_inc;
  logic [14:0] new_addr;
  logic [14:0] ent_addr [SEQ_DEPTH];
  logic [7:0]  ent_val [SEQ_DEPTH];
  logic        unlock_pre, id_ok, prog_ok, erase_pre, sector_ok, chip_ok;
  logic [19:0] byte_off;
  logic [18:0] flash_off, sector_off;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[CFG_ADDR_W-1:2] == REG_FLASH_ENABLE);
  assign prdata = (paddr[CFG_ADDR_W-1:2] == REG_FLASH_ENABLE) ? {31'd0, flash_enable_q} : 32'd0;
  assign flash_enable_d = cfg_we ? pwdata[0] : flash_enable_q;

  assign advance     = stg_valid_q && (!res_valid_q || out_o.ready);
  assign in_i.ready  = !stg_valid_q || advance;
  assign in_fire     = in_i.valid && in_i.ready;
  assign stg_valid_d = in_fire || (stg_valid_q && !advance);
  assign res_valid_d = advance || (res_valid_q && !out_o.ready);
  assign out_o.valid   = res_valid_q;
  assign out_o.payload = res_q;

  assign upper_half    = stg_q.cpu_addr[15] && stg_q.cpu_addr[14];
  assign seq_count_inc = seq_count_q + 4'd1;
  assign new_addr      = {bank_latch_q[0], stg_q.cpu_addr[13:0]};
  assign rec_en        = flash_enable_q && !upper_half
                         && (seq_count_q < 4'(SEQUENCE_LIMIT))
                         && (seq_count_q < 4'(SEQ_DEPTH));

  always_comb begin
    for (int k = 0; k < SEQ_DEPTH; k++) begin
      if (rec_en && (seq_count_q[SEQ_IDX_W-1:0] == SEQ_IDX_W'(k))) begin
        ent_addr[k] = new_addr;
        ent_val[k]  = stg_q.write_data;
      end else begin
        ent_addr[k] = seq_addr_q[k];
        ent_val[k]  = seq_val_q[k];
      end
    end
  end

  assign unlock_pre = (ent_addr[0] == CMD_ADDR_A) && (ent_val[0] == CMD_UNLOCK_1)
                      && (ent_addr[1] == CMD_ADDR_B) && (ent_val[1] == CMD_UNLOCK_2);
  assign id_ok      = unlock_pre && (ent_addr[2] == CMD_ADDR_A) && (ent_val[2] == CMD_ID_ENTRY);
  assign prog_ok    = unlock_pre && (ent_addr[2] == CMD_ADDR_A) && (ent_val[2] == CMD_PROGRAM);
  assign erase_pre  = unlock_pre && (ent_addr[2] == CMD_ADDR_A) && (ent_val[2] == CMD_ERASE)
                      && (ent_addr[3] == CMD_ADDR_A) && (ent_val[3] == CMD_UNLOCK_1)
                      && (ent_addr[4] == CMD_ADDR_B) && (ent_val[4] == CMD_UNLOCK_2);
  assign sector_ok  = ent_val[5] == CMD_SECTOR;
  assign chip_ok    = (ent_addr[5] == CMD_ADDR_A) && (ent_val[5] == CMD_CHIP);

  assign byte_off   = {1'b0, bank_latch_q[4:0], stg_q.cpu_addr[13:0]};
  assign flash_off  = 19'(byte_off % 20'(FLASH_BYTES));
  assign sector_off = flash_off - 19'(flash_off % 19'(SECTOR_BYTES));

  always_comb begin
    bank_latch_d = bank_latch_q;
    seq_count_d  = seq_count_q;
    id_mode_d    = id_mode_q;
    res_d.flash_op     = OP_NONE;
    res_d.flash_offset = '0;
    res_d.flash_byte   = '0;
    if (!flash_enable_q) begin
      bank_latch_d = stg_q.write_data & stg_q.current_byte;
    end else if (upper_half) begin
      bank_latch_d = stg_q.write_data;
    end else begin
      if (seq_count_q < 4'(SEQUENCE_LIMIT)) begin
        seq_count_d = seq_count_inc;
        if ((seq_count_inc == 4'(UNLOCK_LEN)) && id_ok) begin
          id_mode_d   = 1'b1;
          seq_count_d = '0;
        end
        if ((seq_count_inc == 4'(ERASE_LEN)) && erase_pre) begin
          if (sector_ok) begin
            res_d.flash_op     = OP_SECTOR_ERASE;
            res_d.flash_offset = sector_off;
            seq_count_d        = '0;
          end else if (chip_ok) begin
            res_d.flash_op = OP_CHIP_ERASE;
            seq_count_d    = '0;
          end
        end
        if ((seq_count_inc == 4'(PROGRAM_LEN)) && prog_ok) begin
          res_d.flash_op     = (stg_q.current_byte == ERASED_BYTE) ? OP_PROGRAM : OP_REFUSED;
          res_d.flash_offset = flash_off;
          res_d.flash_byte   = stg_q.write_data;
          seq_count_d        = '0;
        end
      end
      if ((stg_q.cpu_addr[11:0] != PAT_ADDR_A) && (stg_q.cpu_addr[11:0] != PAT_ADDR_B)) begin
        seq_count_d = '0;
      end
      if (stg_q.write_data == CMD_RESET) begin
        seq_count_d = '0;
        id_mode_d   = 1'b0;
      end
    end
    res_d.prg_bank         = bank_latch_d[4:0];
    res_d.chr_bank         = bank_latch_d[6:5];
    res_d.nametable_select = bank_latch_d[7];
    if (!flash_enable_q) begin
      res_d.prg_source = SRC_ROM;
    end else if (id_mode_d) begin
      res_d.prg_source = SRC_ID;
    end else begin
      res_d.prg_source = SRC_FLASH;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flash_enable_q <= 1'b0;
      stg_valid_q    <= 1'b0;
      res_valid_q    <= 1'b0;
      bank_latch_q   <= '0;
      seq_count_q    <= '0;
      id_mode_q      <= 1'b0;
    end else begin
      flash_enable_q <= flash_enable_d;
      stg_valid_q    <= stg_valid_d;
      res_valid_q    <= res_valid_d;
      if (advance) begin
        bank_latch_q <= bank_latch_d;
        seq_count_q  <= seq_count_d;
        id_mode_q    <= id_mode_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      stg_q <= in_i.payload;
    end
    if (advance) begin
      res_q <= res_d;
    end
    if (advance && rec_en) begin
      seq_addr_q[seq_count_q[SEQ_IDX_W-1:0]] <= new_addr;
      seq_val_q[seq_count_q[SEQ_IDX_W-1:0]]  <= stg_q.write_data;
    end
  end

endmodule

// File: test/tb_bank_latch_with_flash_command_decoder_core.sv
module tb_bank_latch_with_flash_command_decoder_core;
  import blfcd_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam logic [15:0] CPU_CMD_A = 16'h9555;
  localparam logic [15:0] CPU_CMD_B = 16'hAAAA;

  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_ENABLE
  } row_kind_e;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_PATTERN,
    RX_RANDOM
  } rx_mode_e;

  typedef enum logic [2:0] {
    SEQ_ID,
    SEQ_PROGRAM,
    SEQ_SECTOR,
    SEQ_CHIP,
    SEQ_RESET,
    SEQ_PATTERN
  } seq_kind_e;

  typedef struct packed {
    row_kind_e  kind;
    blfcd_in_t  bus;
    logic       typed;
    blfcd_out_t fixed;
  } dir_row_t;

  localparam blfcd_out_t NO_RESULT = '0;

  dir_row_t directed_rows [28] = '{
    '{ROW_WRITE, '{16'hFFFF, 8'hFF, 8'h00}, 1'b1,
      '{5'd0, 2'd0, 1'b0, SRC_ROM, OP_NONE, 19'd0, 8'd0}},
    '{ROW_WRITE, '{16'h8000, 8'hFF, 8'hFF}, 1'b1,
      '{5'd31, 2'd3, 1'b1, SRC_ROM, OP_NONE, 19'd0, 8'd0}},
    '{ROW_ENABLE, '{16'h0000, 8'h01, 8'h00}, 1'b0, NO_RESULT},
    '{ROW_WRITE, '{CPU_CMD_A, CMD_UNLOCK_1, 8'h00}, 1'b0, NO_RESULT},
    '{ROW_WRITE, '{16'hC000, 8'h00, 8'h00}, 1'b0, NO_RESULT},
    '{ROW_WRITE, '{CPU_CMD_B, CMD_UNLOCK_2, 8'h00}, 1'b0, NO_RESULT},
    '{ROW_WRITE, '{16'hC000, 8'h01, 8'h00}, 1'b0, NO_RESULT},
    '{ROW_WRITE, '{CPU_CMD_A, CMD_ERASE, 8'h00}, 1'b0, NO_RESULT},
    '{ROW_WRITE, '{CPU_CMD_A, CMD_UNLOCK_1, 8'h00}, 1'b0, NO_RESULT},
    '{ROW_WRITE, '{16'hC000, 8'h00, 8'h00}, 1'b0, NO_RESULT},
    '{ROW_WRITE, '{CPU_CMD_B, CMD_UNLOCK_2, 8'h00}, 1'b0, NO_RESULT},
    '{ROW_WRITE, '{16'hC000, 8'h01, 8'h00}, 1'b0, NO_RESULT},
    '{ROW_WRITE, '{CPU_CMD_A, CMD_CHIP, 8'h00}, 1'b1,
      '{5'd1, 2'd0, 1'b0, SRC_FLASH, OP_CHIP_ERASE, 19'd0, 8'd0}},
    '{ROW_WRITE, '{CPU_CMD_A, CMD_UNLOCK_1, 8'h00}, 1'b0, NO_RESULT},
    '{ROW_WRITE, '{16'hC000, 8'h00, 8'hFF}, 1'b0, NO_RESULT},
    '{ROW_WRITE, '{CPU_CMD_B, CMD_UNLOCK_2, 8'h00}, 1'b0, NO_RESULT},
    '{ROW_WRITE, '{16'hC000, 8'h1F, 8'h00}, 1'b0, NO_RESULT},
    '{ROW_WRITE, '{CPU_CMD_A, CMD_PROGRAM, 8'h00}, 1'b0, NO_RESULT},
    '{ROW_WRITE, '{16'hBFFF, 8'h00, 8'h00}, 1'b1,
      '{5'd31, 2'd0, 1'b0, SRC_FLASH, OP_REFUSED, 19'h7FFFF, 8'h00}},
    '{ROW_WRITE, '{CPU_CMD_A, CMD_UNLOCK_1, 8'h00}, 1'b0, NO_RESULT},
    '{ROW_WRITE, '{16'hC000, 8'h80, 8'h00}, 1'b0, NO_RESULT},
    '{ROW_WRITE, '{CPU_CMD_B, CMD_UNLOCK_2, 8'h00}, 1'b0, NO_RESULT},
    '{ROW_WRITE, '{16'hC000, 8'h61, 8'h00}, 1'b0, NO_RESULT},
    '{ROW_WRITE, '{CPU_CMD_A, CMD_ERASE, 8'h00}, 1'b0, NO_RESULT},
    '{ROW_WRITE, '{CPU_CMD_A, CMD_UNLOCK_1, 8'h00}, 1'b0, NO_RESULT},
    '{ROW_WRITE, '{16'hC000, 8'h7E, 8'h00}, 1'b0, NO_RESULT},
    '{ROW_WRITE, '{CPU_CMD_B, CMD_UNLOCK_2, 8'h00}, 1'b0, NO_RESULT},
    '{ROW_WRITE, '{16'h8123, CMD_SECTOR, 8'h5A}, 1'b0, NO_RESULT}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  blfcd_stream_if #(.payload_t(blfcd_in_t))  write_if ();
  blfcd_stream_if #(.payload_t(blfcd_out_t)) decode_if ();

  bank_latch_with_flash_command_decoder_core dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (write_if),
    .out_o   (decode_if)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // Shadow copy of the decoder state.
  logic        flash_en_m;
  logic [7:0]  bank_m;
  int unsigned seq_len_m;
  logic        id_mode_m;
  logic [14:0] seq_addr_m [SEQ_DEPTH];
  logic [7:0]  seq_data_m [SEQ_DEPTH];

  blfcd_out_t expected_decodes [$];
  int mismatches = 0;
  int issued = 0;
  int burst_left = 0;
  int rx_hold = 0;
  int rx_cycle = 0;
  rx_mode_e rx_mode = RX_OPEN;
  logic [10:0] rx_pattern = 11'b10110011101;

  function automatic logic seq_entry_is(int k, logic [14:0] a, logic [7:0] v);
    return seq_addr_m[SEQ_IDX_W'(k)] == a && seq_data_m[SEQ_IDX_W'(k)] == v;
  endfunction

  function automatic logic unlocked(logic [7:0] third);
    return seq_entry_is(0, CMD_ADDR_A, CMD_UNLOCK_1) &&
           seq_entry_is(1, CMD_ADDR_B, CMD_UNLOCK_2) &&
           seq_entry_is(2, CMD_ADDR_A, third);
  endfunction

  function automatic blfcd_out_t decode_write(blfcd_in_t w);
    blfcd_out_t r;
    logic [18:0] off;
    r = '0;
    if (!flash_en_m) begin
      bank_m = w.write_data & w.current_byte;
    end else if (w.cpu_addr >= 16'hC000) begin
      bank_m = w.write_data;
    end else begin
      off = 19'({bank_m[4:0], w.cpu_addr[13:0]} % FLASH_BYTES);
      if (seq_len_m < SEQUENCE_LIMIT) begin
        if (seq_len_m < SEQ_DEPTH) begin
          seq_addr_m[SEQ_IDX_W'(seq_len_m)] = {bank_m[0], w.cpu_addr[13:0]};
          seq_data_m[SEQ_IDX_W'(seq_len_m)] = w.write_data;
        end
        seq_len_m++;
        if (seq_len_m == UNLOCK_LEN && unlocked(CMD_ID_ENTRY)) begin
          id_mode_m = 1'b1;
          seq_len_m = 0;
        end
        if (seq_len_m == ERASE_LEN && unlocked(CMD_ERASE) &&
            seq_entry_is(3, CMD_ADDR_A, CMD_UNLOCK_1) &&
            seq_entry_is(4, CMD_ADDR_B, CMD_UNLOCK_2)) begin
          if (seq_data_m[5] == CMD_SECTOR) begin
            r.flash_op = OP_SECTOR_ERASE;
            r.flash_offset = 19'(off - off % SECTOR_BYTES);
            seq_len_m = 0;
          end else if (seq_entry_is(5, CMD_ADDR_A, CMD_CHIP)) begin
            r.flash_op = OP_CHIP_ERASE;
            seq_len_m = 0;
          end
        end
        if (seq_len_m == PROGRAM_LEN && unlocked(CMD_PROGRAM)) begin
          r.flash_op = (w.current_byte == ERASED_BYTE) ? OP_PROGRAM : OP_REFUSED;
          r.flash_offset = off;
          r.flash_byte = w.write_data;
          seq_len_m = 0;
        end
      end
      if (w.cpu_addr[11:0] != PAT_ADDR_A && w.cpu_addr[11:0] != PAT_ADDR_B) begin
        seq_len_m = 0;
      end
      if (w.write_data == CMD_RESET) begin
        seq_len_m = 0;
        id_mode_m = 1'b0;
      end
    end
    r.prg_bank = bank_m[4:0];
    r.chr_bank = bank_m[6:5];
    r.nametable_select = bank_m[7];
    r.prg_source = !flash_en_m ? SRC_ROM : (id_mode_m ? SRC_ID : SRC_FLASH);
    return r;
  endfunction

  task automatic check_decode(blfcd_out_t e, blfcd_out_t a);
    logic bad;
    bad = 1'b0;
    if (a.prg_bank !== e.prg_bank) begin
      $error("prg_bank: expected %0d, got %0d", e.prg_bank, a.prg_bank);
      bad = 1'b1;
    end
    if (a.chr_bank !== e.chr_bank) begin
      $error("chr_bank: expected %0d, got %0d", e.chr_bank, a.chr_bank);
      bad = 1'b1;
    end
    if (a.nametable_select !== e.nametable_select) begin
      $error("nametable_select: expected %0d, got %0d", e.nametable_select,
             a.nametable_select);
      bad = 1'b1;
    end
    if (a.prg_source !== e.prg_source) begin
      $error("prg_source: expected %0d, got %0d", e.prg_source, a.prg_source);
      bad = 1'b1;
    end
    if (a.flash_op !== e.flash_op) begin
      $error("flash_op: expected %0d, got %0d", e.flash_op, a.flash_op);
      bad = 1'b1;
    end
    if (a.flash_offset !== e.flash_offset) begin
      $error("flash_offset: expected %h, got %h", e.flash_offset, a.flash_offset);
      bad = 1'b1;
    end
    if (a.flash_byte !== e.flash_byte) begin
      $error("flash_byte: expected %h, got %h", e.flash_byte, a.flash_byte);
      bad = 1'b1;
    end
    if (bad) mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst_n && decode_if.valid && decode_if.ready) begin
      if (expected_decodes.size() == 0) begin
        $error("result item arrived with nothing expected");
        mismatches++;
      end else begin
        check_decode(expected_decodes.pop_front(), decode_if.payload);
      end
    end
  end

  // The receiver stalls on a pattern that changes mode now and then.
  initial begin
    decode_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (rx_cycle % 80 == 0) rx_mode = rx_mode_e'($urandom_range(0, 2));
      if (rx_hold != 0) begin
        rx_hold--;
        decode_if.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN: decode_if.ready <= 1'b1;
          RX_PATTERN: decode_if.ready <= rx_pattern[4'(rx_cycle % 11)];
          default: decode_if.ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  task automatic send_write(blfcd_in_t w, logic typed, blfcd_out_t fixed);
    int gap;
    blfcd_out_t predicted;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        write_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end
    write_if.valid <= 1'b1;
    write_if.payload <= w;
    do @(posedge clk); while (!write_if.ready);
    predicted = decode_write(w);
    expected_decodes.push_back(typed ? fixed : predicted);
    issued++;
    burst_left--;
  endtask

  task automatic write_bus(logic [15:0] a, logic [7:0] d, logic [7:0] c);
    send_write(blfcd_in_t'{a, d, c}, 1'b0, NO_RESULT);
  endtask

  task automatic drain_results();
    write_if.valid <= 1'b0;
    burst_left = 0;
    while (expected_decodes.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(int idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'(4 * idx);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_FLASH_ENABLE) flash_en_m = value[0];
  endtask

  task automatic set_latch_bit(logic b);
    logic [7:0] d;
    if (bank_m[0] != b || $urandom_range(0, 7) == 0) begin
      d = 8'($urandom);
      d[0] = b;
      write_bus(16'($urandom_range(16'hC000, 16'hFFFF)), d, 8'($urandom));
    end
  endtask

  task automatic cmd_step(logic at_a, logic [7:0] value);
    logic [15:0] a;
    a = at_a ? CPU_CMD_A : CPU_CMD_B;
    if ($urandom_range(0, 39) == 0) a = a ^ (16'h1 << $urandom_range(0, 13));
    set_latch_bit(at_a);
    write_bus(a, value, 8'($urandom));
  endtask

  task automatic lower_write(logic [7:0] value, logic [7:0] c);
    if ($urandom_range(0, 1) == 1) begin
      write_bus(16'($urandom_range(16'hC000, 16'hFFFF)), 8'($urandom), 8'($urandom));
    end
    write_bus(16'($urandom_range(16'h8000, 16'hBFFF)), value, c);
  endtask

  task automatic random_write();
    logic [7:0] c;
    c = ($urandom_range(0, 3) == 0) ? ERASED_BYTE : 8'($urandom);
    write_bus(16'($urandom_range(16'h8000, 16'hFFFF)), 8'($urandom), c);
  endtask

  task automatic run_command();
    int pick;
    seq_kind_e kind;
    logic [7:0] d;
    pick = $urandom_range(0, 99);
    if (pick < 15) kind = SEQ_ID;
    else if (pick < 45) kind = SEQ_PROGRAM;
    else if (pick < 65) kind = SEQ_SECTOR;
    else if (pick < 80) kind = SEQ_CHIP;
    else if (pick < 90) kind = SEQ_RESET;
    else kind = SEQ_PATTERN;
    if (kind == SEQ_PATTERN) begin
      repeat ($urandom_range(4, 14)) begin
        d = 8'($urandom);
        if (d == CMD_RESET) d = CMD_UNLOCK_1;
        write_bus({2'b10, 2'($urandom), ($urandom_range(0, 1) ? PAT_ADDR_A : PAT_ADDR_B)},
                  d, 8'($urandom));
      end
    end else begin
      cmd_step(1'b1, CMD_UNLOCK_1);
      cmd_step(1'b0, CMD_UNLOCK_2);
      case (kind)
        SEQ_ID: cmd_step(1'b1, CMD_ID_ENTRY);
        SEQ_PROGRAM: begin
          cmd_step(1'b1, CMD_PROGRAM);
          lower_write(8'($urandom),
                      ($urandom_range(0, 1) == 1) ? ERASED_BYTE : 8'($urandom));
        end
        SEQ_SECTOR: begin
          cmd_step(1'b1, CMD_ERASE);
          cmd_step(1'b1, CMD_UNLOCK_1);
          cmd_step(1'b0, CMD_UNLOCK_2);
          lower_write(CMD_SECTOR, 8'($urandom));
        end
        SEQ_CHIP: begin
          cmd_step(1'b1, CMD_ERASE);
          cmd_step(1'b1, CMD_UNLOCK_1);
          cmd_step(1'b0, CMD_UNLOCK_2);
          cmd_step(1'b1, CMD_CHIP);
        end
        default: lower_write(CMD_RESET, 8'($urandom));
      endcase
    end
  endtask

  initial begin
    #(CLK_PERIOD * 400000);
    $display("tb_bank_latch_with_flash_command_decoder_core: errors");
    $finish;
  end

  initial begin
    logic phase_enable [6];
    int target;
    phase_enable = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
    rst_n <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    write_if.valid <= 1'b0;
    write_if.payload <= '0;
    flash_en_m = 1'b0;
    bank_m = '0;
    seq_len_m = 0;
    id_mode_m = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_ENABLE) begin
        drain_results();
        write_reg(REG_FLASH_ENABLE, 32'(directed_rows[i].bus.write_data));
      end else begin
        send_write(directed_rows[i].bus, directed_rows[i].typed, directed_rows[i].fixed);
      end
    end

    for (int p = 0; p < 6; p++) begin
      drain_results();
      write_reg(REG_FLASH_ENABLE, 32'(phase_enable[3'(p)]));
      // The receiver holds off for a long stretch so that the block backs up.
      if (p == 2) rx_hold = 250;
      target = issued + (phase_enable[3'(p)] ? 150 : 60);
      while (issued < target) begin
        if (phase_enable[3'(p)] && $urandom_range(0, 4) != 0) run_command();
        else random_write();
      end
    end

    drain_results();
    if (mismatches == 0 && expected_decodes.size() == 0) begin
      $display("tb_bank_latch_with_flash_command_decoder_core: clean");
    end else begin
      $display("tb_bank_latch_with_flash_command_decoder_core: errors");
    end
    $finish;
  end

endmodule
